>>> sv/sorted_line_number_table_macros.svh
// Assertion macros for the sorted line-number table.
// Real checks in simulation; empty bodies when built for synthesis.
`ifndef SORTED_LINE_NUMBER_TABLE_MACROS_SVH
`define SORTED_LINE_NUMBER_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// Implication checked at every rising edge outside reset
`define SLNT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same check, but also held while reset is asserted
`define SLNT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SLNT_ASSERT(label, clk, rst, prop, msg)
`define SLNT_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

>>> sv/slnt_pkg.sv
package slnt_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Item kinds
  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_INSERT = 1'b1;

  // Input word
  typedef struct packed {
    logic               kind;
    logic signed [31:0] line_number;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic             found;
    logic [7:0]       match_index;
    logic [CNT_W-1:0] insert_position;
    logic             table_full;
    logic [CNT_W-1:0] entry_count;
  } out_word_t;

endpackage

>>> sv/sorted_line_number_table.sv
// Sorted line-number table.
// Holds up to 256 distinct signed 32-bit line numbers in ascending order.
// Input channel (in_valid/in_ready/in_data): kind selects lookup or insert.
// Output channel (out_valid/out_ready/out_data): one result word per input
// word, carrying found flag, match index, insert position, full flag and
// the entry count after the word.
// Each word runs a binary search on a table memory with one read and one
// write port: each halving step reads the middle entry, then compares, and
// a closing check ends the search; then come the equality check at the
// insert point and a decision step, and a lookup then loads the result
// register. An insert of a new number first moves the n - pos later entries
// (n entries stored) up one slot, one entry per cycle with read and write
// overlapped, then writes the number at its insert point before the result
// load. in_ready is high only while the sequencer is idle: a new word is not
// taken until the sequencer is through with the last one.
// The result sits in an output register: the next word may be accepted
// while a result waits; a stalled receiver holds the sequencer at its final
// step until the register frees up.
// Reset empties the table at once (count to zero); memory contents are
// not cleared, as only entries below the count are ever read.
module sorted_line_number_table (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  slnt_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output slnt_pkg::out_word_t out_data
);

  import slnt_pkg::*;

  `include "sorted_line_number_table_macros.svh"

  // Sequencer codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SREQ  = 4'd1;
  localparam logic [3:0] S_SCMP  = 4'd2;
  localparam logic [3:0] S_FREQ  = 4'd3;
  localparam logic [3:0] S_FCMP  = 4'd4;
  localparam logic [3:0] S_DEC   = 4'd5;
  localparam logic [3:0] S_SHIFT = 4'd6;
  localparam logic [3:0] S_INS   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  logic [3:0]         state, state_next;
  logic               kind;
  logic signed [31:0] key;
  logic [CNT_W-1:0]   lo, lo_next;
  logic [CNT_W-1:0]   hi, hi_next;
  logic [CNT_W-1:0]   mid;
  logic [CNT_W-1:0]   cur, cur_next;
  logic               pend, pend_next;
  logic [ADDR_W-1:0]  shift_addr, shift_addr_next;
  logic               found, found_next;
  logic               full, full_next;
  logic [CNT_W-1:0]   stored_count;
  logic               load_out;

  // Table memory
  logic signed [31:0] line_table [TABLE_DEPTH];
  logic signed [31:0] rdata;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic               we;
  logic [ADDR_W-1:0]  wr_addr;
  logic signed [31:0] wr_data;

  logic [CNT_W:0] mid_sum;

  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid      = mid_sum[CNT_W:1];
  assign in_ready = (state == S_IDLE);
  assign load_out = (state == S_DONE) && (!out_valid || out_ready);

  // Memory port: one registered read, one write
  always_ff @(posedge clk) begin
    if (we) begin
      line_table[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= line_table[rd_addr];
    end
  end

  // Sequencer next-state and memory control
  always_comb begin
    state_next      = state;
    lo_next         = lo;
    hi_next         = hi;
    cur_next        = cur;
    pend_next       = pend;
    shift_addr_next = shift_addr;
    found_next      = found;
    full_next       = full;
    rd_en           = 1'b0;
    rd_addr         = mid[ADDR_W-1:0];
    we              = 1'b0;
    wr_addr         = shift_addr;
    wr_data         = rdata;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          lo_next    = '0;
          hi_next    = stored_count;
          found_next = 1'b0;
          full_next  = 1'b0;
          state_next = S_SREQ;
        end
      end
      // halving step: read the middle entry
      S_SREQ: begin
        if (lo < hi) begin
          rd_en      = 1'b1;
          rd_addr    = mid[ADDR_W-1:0];
          state_next = S_SCMP;
        end else begin
          state_next = S_FREQ;
        end
      end
      S_SCMP: begin
        if (rdata < key) begin
          lo_next = mid + CNT_W'(1);
        end else begin
          hi_next = mid;
        end
        state_next = S_SREQ;
      end
      // equality check at the insert point
      S_FREQ: begin
        if (lo < stored_count) begin
          rd_en      = 1'b1;
          rd_addr    = lo[ADDR_W-1:0];
          state_next = S_FCMP;
        end else begin
          state_next = S_DEC;
        end
      end
      S_FCMP: begin
        found_next = (rdata == key);
        state_next = S_DEC;
      end
      S_DEC: begin
        if ((kind == KIND_INSERT) && !found) begin
          if (stored_count == DEPTH_CNT) begin
            full_next  = 1'b1;
            state_next = S_DONE;
          end else begin
            cur_next   = stored_count;
            pend_next  = 1'b0;
            state_next = S_SHIFT;
          end
        end else begin
          state_next = S_DONE;
        end
      end
      // move entries up: read cur-1 while writing the previous read to its slot
      S_SHIFT: begin
        if (pend) begin
          we = 1'b1;
        end
        if (cur > lo) begin
          rd_en           = 1'b1;
          rd_addr         = ADDR_W'(cur - CNT_W'(1));
          cur_next        = cur - CNT_W'(1);
          shift_addr_next = cur[ADDR_W-1:0];
          pend_next       = 1'b1;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            state_next = S_INS;
          end
        end
      end
      S_INS: begin
        we         = 1'b1;
        wr_addr    = lo[ADDR_W-1:0];
        wr_data    = key;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      stored_count <= '0;
      out_valid    <= 1'b0;
      pend         <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
      if (state == S_INS) begin
        stored_count <= stored_count + CNT_W'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers and result word
  always_ff @(posedge clk) begin
    lo         <= lo_next;
    hi         <= hi_next;
    cur        <= cur_next;
    shift_addr <= shift_addr_next;
    found      <= found_next;
    full       <= full_next;
    if (in_valid && in_ready) begin
      kind <= in_data.kind;
      key  <= in_data.line_number;
    end
    if (load_out) begin
      out_data.found           <= found;
      out_data.match_index     <= found ? lo[7:0] : 8'd0;
      out_data.insert_position <= found ? '0 : lo;
      out_data.table_full      <= full;
      out_data.entry_count     <= stored_count;
    end
  end

  // Checks
  `SLNT_ASSERT(a_count_bound, clk, rst, stored_count <= DEPTH_CNT,
    "entry count beyond table depth")
  `SLNT_ASSERT(a_count_only_on_ins, clk, rst, (state != S_INS) |=> $stable(stored_count),
    "entry count changed outside an insert step")
  `SLNT_ASSERT(a_search_window, clk, rst, (state == S_SREQ) |-> (lo <= hi && hi <= stored_count),
    "binary search window out of order")
  `SLNT_ASSERT(a_found_not_full, clk, rst, out_valid |-> !(out_data.found && out_data.table_full),
    "result flags both found and table full")
  `SLNT_ASSERT(a_shift_not_full, clk, rst, (state == S_SHIFT) |-> (stored_count != DEPTH_CNT),
    "entries shifted while table is full")

endmodule
